/* rtl/core/es2cal_pkg.sv */
// ----------------------------------------------------------------------------
// es2cal_pkg
// Shared types, constants and helper functions for the epoch-seconds to
// calendar decoder: datapath operations, divisor codes and month lengths.
// ----------------------------------------------------------------------------
package es2cal_pkg;

   // Calendar origin: Thursday, 1 January 1970
   localparam logic [11:0] EPOCH_YEAR        = 12'd1970;
   localparam logic [2:0]  EPOCH_WEEKDAY     = 3'd4;
   // Only century year in range that is not a leap year
   localparam logic [11:0] NON_LEAP_CENTURY  = 12'd2100;
   localparam logic [3:0]  LAST_MONTH        = 4'd11;
   localparam logic [3:0]  DAYS_PER_WEEK     = 4'd7;

   // Reciprocals for divide by multiply and shift:
   //   x / 60 = ((x >> 2) * RECIP_15) >> 35
   //   x / 24 = ((x >> 3) * RECIP_3)  >> 33
   localparam logic [31:0] RECIP_15          = 32'h8888_8889;
   localparam logic [31:0] RECIP_3           = 32'hAAAA_AAAB;

   // Divisor selection for the shared reciprocal multiplier
   typedef enum logic {
      DIV_BY_60,
      DIV_BY_24
   } div_sel_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_SEC_END,
      OP_MIN_END,
      OP_HOUR_END,
      OP_YEAR,
      OP_WDAY,
      OP_MONTH
   } op_type;

   typedef struct packed {
      op_type      op;
      div_sel_type dsel;
      logic        publish;
   } dp_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } dp_status_type;

   // Length of a zero-based month, February lengthened in leap years
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd1:                    len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* rtl/core/es2cal_if.sv */
// ----------------------------------------------------------------------------
// es2cal_if
// Valid/ready channels of the calendar decoder: the request channel carries
// a seconds count, the response channel the decoded calendar fields.
// ----------------------------------------------------------------------------
interface es2cal_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2cal_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [4:0]  day_of_month;
   logic [3:0]  month_number;
   logic [11:0] year_number;
   logic [2:0]  weekday;
   logic [8:0]  day_of_year;

   modport source (output valid, output second, output minute, output hour,
                   output day_of_month, output month_number, output year_number,
                   output weekday, output day_of_year, input ready);
   modport sink   (input valid, input second, input minute, input hour,
                   input day_of_month, input month_number, input year_number,
                   input weekday, input day_of_year, output ready);
endinterface

/* rtl/core/es2cal_dp.sv */
// ----------------------------------------------------------------------------
// es2cal_dp
// Datapath: a shared reciprocal multiplier for division by 60 or 24, the year
// and month subtract loops, and the registered result fields.
// ----------------------------------------------------------------------------
module es2cal_dp
   import es2cal_pkg::*;
(
   input  logic          clock,
   input  logic [31:0]   epoch_seconds,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic [5:0]    second,
   output logic [5:0]    minute,
   output logic [4:0]    hour,
   output logic [4:0]    day_of_month,
   output logic [3:0]    month_number,
   output logic [11:0]   year_number,
   output logic [2:0]    weekday,
   output logic [8:0]    day_of_year
);

   // Working registers
   logic [31:0] num_ff, num_in;
   logic [30:0] prod_ff, prod_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [2:0]  wday_ff, wday_in;
   logic [8:0]  yday_ff, yday_in;
   logic [3:0]  month_ff, month_in;

   // Result registers
   logic [5:0]  out_sec_ff;
   logic [5:0]  out_min_ff;
   logic [4:0]  out_hour_ff;
   logic [4:0]  out_mday_ff;
   logic [3:0]  out_month_ff;
   logic [11:0] out_year_ff;
   logic [2:0]  out_wday_ff;
   logic [8:0]  out_yday_ff;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_prod;
   logic [31:0] quo;
   logic [31:0] quo_scaled;
   logic [31:0] rem_full;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [3:0]  wsum;
   logic [2:0]  wday_next;
   logic [8:0]  wday_total;
   logic [4:0]  wday_fold;
   logic [3:0]  wday_fold2;
   logic [2:0]  wday_mod;

   // Multiply the dividend, stripped of its power-of-two factor, by the reciprocal
   always_comb begin
      if (cmd.dsel == DIV_BY_24) begin
         mul_a = {3'd0, num_ff[31:3]};
         mul_b = RECIP_3;
      end else begin
         mul_a = {2'd0, num_ff[31:2]};
         mul_b = RECIP_15;
      end
      mul_prod = {32'd0, mul_a} * {32'd0, mul_b};
   end

   // Take the quotient from the registered product; remainder by back-multiply
   always_comb begin
      if (cmd.dsel == DIV_BY_24) begin
         quo        = {1'b0, prod_ff};
         quo_scaled = {quo[27:0], 4'd0} + {quo[28:0], 3'd0};
      end else begin
         quo        = {3'd0, prod_ff[30:2]};
         quo_scaled = {quo[25:0], 6'd0} - {quo[29:0], 2'd0};
      end
      rem_full = num_ff - quo_scaled;
   end

   // Leap rule over 1970..2106: multiple of four, except 2100
   always_comb begin
      leap = (year_ff[1:0] == 2'b00) && (year_ff != NON_LEAP_CENTURY);
      ylen = leap ? 9'd366 : 9'd365;
      mlen = month_len(month_ff, leap);
      wsum = {1'b0, wday_ff} + (leap ? 4'd2 : 4'd1);
      wday_next  = (wsum >= DAYS_PER_WEEK) ? 3'(wsum - DAYS_PER_WEEK) : wsum[2:0];
   end

   // Weekday sum modulo seven: fold octal digits, since eight is one mod seven
   always_comb begin
      wday_total = {6'd0, wday_ff} + days_ff[8:0];
      wday_fold  = {2'd0, wday_total[2:0]} + {2'd0, wday_total[5:3]}
                 + {2'd0, wday_total[8:6]};
      wday_fold2 = {1'b0, wday_fold[2:0]} + {2'd0, wday_fold[4:3]};
      wday_mod   = (wday_fold2 >= DAYS_PER_WEEK) ? 3'(wday_fold2 - DAYS_PER_WEEK)
                                                 : wday_fold2[2:0];
   end

   always_comb begin
      status.year_done  = (days_ff < {7'd0, ylen});
      status.month_done = (days_ff < {11'd0, mlen}) || (month_ff == LAST_MONTH);
   end

   // Next-state of the working registers
   always_comb begin
      num_in   = num_ff;
      prod_in  = prod_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      wday_in  = wday_ff;
      yday_in  = yday_ff;
      month_in = month_ff;
      case (cmd.op)
         OP_LOAD: begin
            num_in = epoch_seconds;
         end
         OP_MUL: begin
            prod_in = mul_prod[63:33];
         end
         OP_SEC_END: begin
            // Minutes go on to the next division
            sec_in = rem_full[5:0];
            num_in = quo;
         end
         OP_MIN_END: begin
            // Hours go on to the next division
            min_in = rem_full[5:0];
            num_in = quo;
         end
         OP_HOUR_END: begin
            hour_in = rem_full[4:0];
            days_in = quo[15:0];
            year_in = EPOCH_YEAR;
            wday_in = EPOCH_WEEKDAY;
         end
         OP_YEAR: begin
            days_in = days_ff - {7'd0, ylen};
            wday_in = wday_next;
            year_in = year_ff + 12'd1;
         end
         OP_WDAY: begin
            yday_in  = days_ff[8:0];
            wday_in  = wday_mod;
            month_in = 4'd0;
         end
         OP_MONTH: begin
            days_in  = days_ff - {11'd0, mlen};
            month_in = month_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      wday_ff  <= wday_in;
      yday_ff  <= yday_in;
      month_ff <= month_in;
   end

   // Capture the finished item into the result register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_sec_ff   <= sec_ff;
         out_min_ff   <= min_ff;
         out_hour_ff  <= hour_ff;
         out_mday_ff  <= days_ff[4:0] + 5'd1;
         out_month_ff <= month_ff + 4'd1;
         out_year_ff  <= year_ff;
         out_wday_ff  <= wday_ff;
         out_yday_ff  <= yday_ff;
      end
   end

   assign second       = out_sec_ff;
   assign minute       = out_min_ff;
   assign hour         = out_hour_ff;
   assign day_of_month = out_mday_ff;
   assign month_number = out_month_ff;
   assign year_number  = out_year_ff;
   assign weekday      = out_wday_ff;
   assign day_of_year  = out_yday_ff;

endmodule

/* rtl/core/es2cal_ctrl.sv */
// ----------------------------------------------------------------------------
// es2cal_ctrl
// Controller: sequences the three time divisions, the year walk, the weekday
// reduction and the month walk, and hands the item to the response register.
// ----------------------------------------------------------------------------
module es2cal_ctrl
   import es2cal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_SEC   = 7'b000_0010,
      ST_MIN   = 7'b000_0100,
      ST_HOUR  = 7'b000_1000,
      ST_YEAR  = 7'b001_0000,
      ST_MONTH = 7'b010_0000,
      ST_DONE  = 7'b100_0000
   } state_type;

   state_type  state_ff, state_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd.op      = OP_NONE;
      cmd.dsel    = DIV_BY_60;
      cmd.publish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Take a new item
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               phase_in = 1'b0;
               state_in = ST_SEC;
            end
         end
         ST_SEC: begin
            // Multiply, then split off the second
            cmd.dsel = DIV_BY_60;
            if (phase_ff) begin
               cmd.op   = OP_SEC_END;
               phase_in = 1'b0;
               state_in = ST_MIN;
            end else begin
               cmd.op   = OP_MUL;
               phase_in = 1'b1;
            end
         end
         ST_MIN: begin
            // Multiply, then split off the minute
            cmd.dsel = DIV_BY_60;
            if (phase_ff) begin
               cmd.op   = OP_MIN_END;
               phase_in = 1'b0;
               state_in = ST_HOUR;
            end else begin
               cmd.op   = OP_MUL;
               phase_in = 1'b1;
            end
         end
         ST_HOUR: begin
            // Multiply, then split off the hour
            cmd.dsel = DIV_BY_24;
            if (phase_ff) begin
               cmd.op   = OP_HOUR_END;
               phase_in = 1'b0;
               state_in = ST_YEAR;
            end else begin
               cmd.op   = OP_MUL;
               phase_in = 1'b1;
            end
         end
         ST_YEAR: begin
            // Strip one whole year per cycle, then reduce the weekday
            if (status.year_done) begin
               cmd.op   = OP_WDAY;
               state_in = ST_MONTH;
            end else begin
               cmd.op = OP_YEAR;
            end
         end
         ST_MONTH: begin
            // Strip one whole month per cycle
            if (status.month_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.op = OP_MONTH;
            end
         end
         ST_DONE: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on publish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/epoch_seconds_to_calendar_unit.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Decodes a 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, day of month, month, year, weekday and day of year.
//
// Usage:
//   req_chan  valid/ready sink, one seconds count per item.
//   rsp_chan  valid/ready source, one calendar item per request item.
//   An item moves on a rising clock edge with valid and ready both high.
// Sequence: load the item; divide by 60, 60 and 24, each a multiply on a
//   shared reciprocal multiplier and then a split of quotient and
//   remainder; walk the years, one per cycle, then reduce the weekday;
//   walk the months, one per cycle; then publish the result.
// Throughput: one item at a time; req_chan.ready is high only while idle,
//   and the next item can be taken in the cycle after a result is published.
// Stall: a result waits in the response register while rsp_chan.ready is
//   low; the unit still takes and decodes the next item, then holds it
//   until the register frees.
// Reset: synchronous, active high; returns to idle with no response valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit
   import es2cal_pkg::*;
(
   input logic          clock,
   input logic          reset,
   es2cal_req_if.sink   req_chan,
   es2cal_rsp_if.source rsp_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   es2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   es2cal_dp u_dp (
      .clock         (clock),
      .epoch_seconds (req_chan.epoch_seconds),
      .cmd           (dp_cmd),
      .status        (dp_status),
      .second        (rsp_chan.second),
      .minute        (rsp_chan.minute),
      .hour          (rsp_chan.hour),
      .day_of_month  (rsp_chan.day_of_month),
      .month_number  (rsp_chan.month_number),
      .year_number   (rsp_chan.year_number),
      .weekday       (rsp_chan.weekday),
      .day_of_year   (rsp_chan.day_of_year)
   );

endmodule

/* sim/calendar_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches the request and response channels of the calendar decoder. Every
// accepted seconds count is decoded into its expected calendar fields. Every
// accepted response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module calendar_checker (
   input  logic  clock,
   input  logic  reset,
   es2cal_req_if req_mon,
   es2cal_rsp_if rsp_mon,
   output int    error_count,
   output int    pending_count
);

   localparam int unsigned BASE_YEAR    = 1970;
   localparam int unsigned BASE_WEEKDAY = 4;    // 1 January 1970 was a Thursday
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                               31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] year_number;
      logic [2:0]  weekday;
      logic [8:0]  day_of_year;
   } calendar_fields_type;

   calendar_fields_type expected_dates [$];
   int                  mismatches;

   assign error_count   = mismatches;
   assign pending_count = expected_dates.size();

   // Break a seconds count down into Gregorian date and time of day
   function automatic calendar_fields_type decode_epoch(input logic [31:0] secs);
      calendar_fields_type fields;
      int unsigned      total_min;
      int unsigned      total_hour;
      int unsigned      days;
      int unsigned      year;
      int unsigned      wday;
      int unsigned      year_len;
      int unsigned      month;
      int unsigned      month_days;
      bit               leap;
      fields.second = 6'(secs % 60);
      total_min     = secs / 60;
      fields.minute = 6'(total_min % 60);
      total_hour    = total_min / 60;
      fields.hour   = 5'(total_hour % 24);
      days          = total_hour / 24;
      year          = BASE_YEAR;
      wday          = BASE_WEEKDAY;
      // walk whole years; a leap year moves the weekday by two
      forever begin
         leap     = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
         year_len = leap ? 366 : 365;
         if (days < year_len) break;
         days -= year_len;
         wday  = (wday + (leap ? 2 : 1)) % 7;
         year++;
      end
      fields.day_of_year = 9'(days);
      fields.year_number = 12'(year);
      fields.weekday     = 3'((wday + days) % 7);
      // walk months, February one day longer in leap years
      month = 0;
      forever begin
         month_days = MONTH_DAYS[month] + ((month == 1 && leap) ? 1 : 0);
         if (month == 11 || days < month_days) break;
         days -= month_days;
         month++;
      end
      fields.day_of_month = 5'(days + 1);
      fields.month_number = 4'(month + 1);
      return fields;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   initial mismatches = 0;

   // Predict on request items, compare on response items
   always @(posedge clock) begin
      calendar_fields_type exp_date;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            expected_dates.push_back(decode_epoch(req_mon.epoch_seconds));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_dates.size() == 0) begin
               $error("response item with no request outstanding");
               mismatches++;
            end else begin
               exp_date = expected_dates.pop_front();
               check_field("second", 32'(exp_date.second), 32'(rsp_mon.second));
               check_field("minute", 32'(exp_date.minute), 32'(rsp_mon.minute));
               check_field("hour", 32'(exp_date.hour), 32'(rsp_mon.hour));
               check_field("day_of_month", 32'(exp_date.day_of_month),
                           32'(rsp_mon.day_of_month));
               check_field("month_number", 32'(exp_date.month_number),
                           32'(rsp_mon.month_number));
               check_field("year_number", 32'(exp_date.year_number),
                           32'(rsp_mon.year_number));
               check_field("weekday", 32'(exp_date.weekday), 32'(rsp_mon.weekday));
               check_field("day_of_year", 32'(exp_date.day_of_year),
                           32'(rsp_mon.day_of_year));
            end
         end
      end
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives seconds counts into the calendar decoder: a directed set of edge
// dates first, then random counts biased toward day boundaries and the top of the 32-bit range.
// Both channels idle in random bursts; the checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_ITEMS  = 2000;
   localparam int QUIET_TAIL    = 200;    // last items run with no idling
   localparam int STALL_LIMIT   = 3000;   // cycles with no item moving
   localparam int DRAIN_CYCLES  = 250;    // longest decode plus margin
   localparam int LAST_DAY      = 49710;  // last day that begins in 32-bit range
   localparam int SECS_PER_DAY  = 86400;

   logic clock;
   logic reset;
   bit   idling_on;
   int   error_count;
   int   pending_count;
   int   quiet_cycles;
   int   item_index;
   int   total_items;

   logic [31:0] directed_secs [] = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
      32'd86399, 32'd86400,
      32'd31535999,                   // last second of 1970
      32'd31536000,                   // first second of 1971
      32'd68169600,                   // 29 February 1972
      32'd94608000,                   // 31 December 1972, day 365
      32'd946684800,                  // 1 January 2000
      32'd951782400,                  // 29 February 2000, leap century
      32'd4107456000,                 // 28 February 2100, not a leap year
      32'd4107542400,                 // 1 March 2100
      32'd2147483647, 32'd2147483648,
      32'hAAAA_AAAA, 32'h5555_5555,
      32'd4291747200                  // 1 January 2106
   };

   es2cal_req_if req_chan ();
   es2cal_rsp_if rsp_chan ();

   epoch_seconds_to_calendar_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   calendar_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Present one seconds count and hold it until accepted
   task automatic send_seconds(input logic [31:0] secs);
      req_chan.valid         <= 1'b1;
      req_chan.epoch_seconds <= secs;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   // Pick a random count, mostly near midnight or at a random time of day
   function automatic logic [31:0] random_seconds();
      longint unsigned secs;
      longint unsigned day;
      day = $urandom_range(0, LAST_DAY);
      case ($urandom_range(0, 4))
         0:       secs = $urandom();
         1:       secs = day * SECS_PER_DAY;
         2:       secs = day * SECS_PER_DAY + SECS_PER_DAY - 1;
         3:       secs = 64'hFFFF_FFFF - $urandom_range(0, 1 << 24);
         default: secs = day * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
      endcase
      if (secs > 64'hFFFF_FFFF) secs = $urandom();
      return secs[31:0];
   endfunction

   // Result side: stall in random bursts while idling is on
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Count cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      reset                  <= 1'b1;
      idling_on              = 1'b0;
      req_chan.valid         <= 1'b0;
      req_chan.epoch_seconds <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      total_items = directed_secs.size() + RANDOM_ITEMS;
      for (item_index = 0; item_index < total_items; item_index++) begin
         // idle in stretches, with quiet stretches between and at the end
         idling_on = (item_index % 300 < 200) && (item_index < total_items - QUIET_TAIL);
         if (item_index < directed_secs.size())
            send_seconds(directed_secs[item_index]);
         else
            send_seconds(random_seconds());
      end
      idling_on = 1'b0;
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
